// ===== design/tee_pkg.sv =====
// ----------------------------------------------------------------------------
// tee_pkg
// Shared types and codes for the timed event expiry table.
// ----------------------------------------------------------------------------
package tee_pkg;

  // Fixed field widths of the channels
  localparam int IN_TIME_W = 32;
  localparam int ID_W      = 16;
  localparam int KIND_W    = 2;

  typedef logic [IN_TIME_W-1:0] in_time_t;
  typedef logic [ID_W-1:0]      id_t;
  typedef logic [KIND_W-1:0]    kind_t;

  // Input command codes
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Result kinds
  localparam kind_t KIND_ACCEPT = 2'd0;
  localparam kind_t KIND_FULL   = 2'd1;
  localparam kind_t KIND_FIRED  = 2'd2;

endpackage

// ===== design/tee_front.sv =====
// ----------------------------------------------------------------------------
// tee_front
// Input side: takes command words, works out the trigger time of an add or
// the masked current time of a tick, and pushes the result into the queue.
// ----------------------------------------------------------------------------
module tee_front #(
  parameter int TIME_BITS = 32
) (
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_cmd,
  input  tee_pkg::in_time_t                      in_now_time,
  input  tee_pkg::in_time_t                      in_delay,
  input  tee_pkg::id_t                           in_target_id,
  input  logic                                   q_full,
  output logic                                   q_push,
  output logic [1+TIME_BITS+tee_pkg::ID_W-1:0]   q_push_data
);
  import tee_pkg::*;

  localparam int EXT_W = (TIME_BITS > IN_TIME_W + 1) ? TIME_BITS : IN_TIME_W + 1;

  logic [EXT_W-1:0]     now_ext;
  logic [EXT_W-1:0]     sum_ext;
  logic [TIME_BITS-1:0] time_sel;

  // Trigger time wraps modulo 2^TIME_BITS
  assign now_ext  = EXT_W'(in_now_time);
  assign sum_ext  = now_ext + EXT_W'(in_delay);
  assign time_sel = (in_cmd == CMD_ADD) ? sum_ext[TIME_BITS-1:0] : now_ext[TIME_BITS-1:0];

  // Accept whenever the queue has room
  assign in_stall    = q_full;
  assign q_push      = in_valid && !q_full;
  assign q_push_data = {in_cmd, time_sel, in_target_id};

endmodule

// ===== design/tee_queue.sv =====
// ----------------------------------------------------------------------------
// tee_queue
// Two-word queue between the front and the table engine.
// ----------------------------------------------------------------------------
module tee_queue #(
  parameter int DATA_W = 49
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output logic [DATA_W-1:0] pop_data
);

  logic [DATA_W-1:0] word_r [2];
  logic              wr_ptr_r;
  logic              rd_ptr_r;
  logic [1:0]        count_r;
  logic [1:0]        count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign pop_data  = word_r[rd_ptr_r];

  // Occupancy
  always_comb begin
    case ({push, pop})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
  end

  // Pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      count_r <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) word_r[wr_ptr_r] <= push_data;
  end

endmodule

// ===== design/tee_back.sv =====
// ----------------------------------------------------------------------------
// tee_back
// Table engine: holds the packed entry table, appends adds, and scans the
// table on a tick, emitting and compacting, one slot a cycle unless stalled.
// ----------------------------------------------------------------------------
module tee_back #(
  parameter int TABLE_DEPTH = 16,
  parameter int TIME_BITS   = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   q_valid,
  input  logic [1+TIME_BITS+tee_pkg::ID_W-1:0]   q_data,
  output logic                                   q_pop,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output tee_pkg::kind_t                         out_kind,
  output tee_pkg::id_t                           out_fired_id,
  output logic                                   out_last,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]       fill_o
);
  import tee_pkg::*;

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int MEM_W = TIME_BITS + ID_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  // Entry table
  logic [MEM_W-1:0] mem [TABLE_DEPTH];

  logic [1:0]           state_r, state_nxt;
  logic [CNT_W-1:0]     fill_r, fill_nxt;
  logic [CNT_W-1:0]     iss_r, iss_nxt;
  logic [CNT_W-1:0]     keep_r, keep_nxt;
  logic [TIME_BITS-1:0] now_r, now_nxt;
  logic                 dv_r, dv_nxt;
  logic                 pend_v_r, pend_v_nxt;
  id_t                  pend_id_r, pend_id_nxt;
  logic [MEM_W-1:0]     rd_data_r;
  logic                 out_valid_r, out_valid_nxt;
  kind_t                out_kind_r, out_kind_nxt;
  id_t                  out_id_r, out_id_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 q_cmd;
  logic [TIME_BITS-1:0] q_time;
  id_t                  q_tid;
  logic [TIME_BITS-1:0] rd_trig;
  id_t                  rd_tid;
  logic                 expired;
  logic                 fire;
  logic                 out_free;
  logic                 hold;
  logic                 rd_en;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [MEM_W-1:0]     wr_data;

  // Queue word fields
  assign q_cmd  = q_data[MEM_W];
  assign q_time = q_data[ID_W +: TIME_BITS];
  assign q_tid  = q_data[ID_W-1:0];

  // Slot under evaluation
  assign rd_trig  = rd_data_r[ID_W +: TIME_BITS];
  assign rd_tid   = rd_data_r[ID_W-1:0];
  assign expired  = (rd_trig <= now_r);
  assign fire     = expired && (rd_tid != '0);
  assign out_free = !out_valid_r || !out_stall;
  // A second fired entry needs the output register for the pending one
  assign hold     = dv_r && fire && pend_v_r && !out_free;

  // Control
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    iss_nxt       = iss_r;
    keep_nxt      = keep_r;
    now_nxt       = now_r;
    dv_nxt        = dv_r;
    pend_v_nxt    = pend_v_r;
    pend_id_nxt   = pend_id_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_id_nxt    = out_id_r;
    out_last_nxt  = out_last_r;
    q_pop         = 1'b0;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = fill_r[IDX_W-1:0];
    wr_data       = {q_time, q_tid};

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_cmd == CMD_ADD) begin
            if (out_free) begin
              q_pop         = 1'b1;
              out_valid_nxt = 1'b1;
              out_id_nxt    = '0;
              out_last_nxt  = 1'b1;
              if (fill_r == CNT_W'(TABLE_DEPTH)) begin
                out_kind_nxt = KIND_FULL;
              end else begin
                out_kind_nxt = KIND_ACCEPT;
                wr_en        = 1'b1;
                fill_nxt     = fill_r + CNT_W'(1);
              end
            end
          end else begin
            q_pop      = 1'b1;
            now_nxt    = q_time;
            iss_nxt    = '0;
            keep_nxt   = '0;
            dv_nxt     = 1'b0;
            pend_v_nxt = 1'b0;
            state_nxt  = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (!hold) begin
          // Evaluate the slot held in the read register
          if (dv_r) begin
            if (!expired) begin
              wr_en    = 1'b1;
              wr_addr  = keep_r[IDX_W-1:0];
              wr_data  = rd_data_r;
              keep_nxt = keep_r + CNT_W'(1);
            end
            if (fire) begin
              if (pend_v_r) begin
                out_valid_nxt = 1'b1;
                out_kind_nxt  = KIND_FIRED;
                out_id_nxt    = pend_id_r;
                out_last_nxt  = 1'b0;
              end
              pend_id_nxt = rd_tid;
              pend_v_nxt  = 1'b1;
            end
          end
          // Issue the next read
          if (iss_r != fill_r) begin
            rd_en   = 1'b1;
            iss_nxt = iss_r + CNT_W'(1);
            dv_nxt  = 1'b1;
          end else begin
            dv_nxt = 1'b0;
          end
          // Scan finished
          if (!dv_r && (iss_r == fill_r)) begin
            fill_nxt  = keep_r;
            state_nxt = pend_v_r ? ST_FLUSH : ST_IDLE;
          end
        end
      end

      ST_FLUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_FIRED;
          out_id_nxt    = pend_id_r;
          out_last_nxt  = 1'b1;
          pend_v_nxt    = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      iss_r       <= '0;
      keep_r      <= '0;
      dv_r        <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      iss_r       <= iss_nxt;
      keep_r      <= keep_nxt;
      dv_r        <= dv_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    now_r      <= now_nxt;
    pend_id_r  <= pend_id_nxt;
    out_kind_r <= out_kind_nxt;
    out_id_r   <= out_id_nxt;
    out_last_r <= out_last_nxt;
  end

  // Table memory, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[iss_r[IDX_W-1:0]];
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_fired_id = out_id_r;
  assign out_last     = out_last_r;
  assign fill_o       = fill_r;

endmodule

// ===== design/timed_event_expiry_table.sv =====
// ----------------------------------------------------------------------------
// timed_event_expiry_table
// Fixed-size table of pending timed events with add and tick commands.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel takes one command word: an add (trigger time is
//   in_now_time + in_delay, wrapped) or a tick carrying the current time.
//   The out_ channel returns one word per add (accepted or table full, last
//   set) and one word per expired entry with a nonzero id on a tick, oldest
//   first, last set on the final one. A tick that fires nothing returns no
//   word. Both channels use valid/stall.
//   An add's word passes through the queue and the output register and
//   waits while a scan runs. Adds are taken one a cycle while no scan runs
//   and the receiver does not stall. A tick reads one slot a cycle through
//   the single read port unless a fired word waits on a stalled receiver.
//   The two-word queue lets the input side keep taking words while a scan
//   runs. Reset empties the table at once; no clearing pass is needed.
//   When the receiver stalls, the output word holds and the scan waits at
//   the next fired entry; the queue fills and then stalls the input.
// ----------------------------------------------------------------------------
module timed_event_expiry_table #(
  parameter int TABLE_DEPTH = 16,
  parameter int TIME_BITS   = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_cmd,
  input  tee_pkg::in_time_t in_now_time,
  input  tee_pkg::in_time_t in_delay,
  input  tee_pkg::id_t      in_target_id,
  output logic              out_valid,
  input  logic              out_stall,
  output tee_pkg::kind_t    out_kind,
  output tee_pkg::id_t      out_fired_id,
  output logic              out_last
);
  import tee_pkg::*;

  localparam int ENT_W = 1 + TIME_BITS + ID_W;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  logic             q_full;
  logic             q_push;
  logic [ENT_W-1:0] q_push_data;
  logic             q_pop;
  logic             q_valid;
  logic [ENT_W-1:0] q_pop_data;
  logic [CNT_W-1:0] fill_cnt;

  // Command intake
  tee_front #(
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_now_time  (in_now_time),
    .in_delay     (in_delay),
    .in_target_id (in_target_id),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_push_data  (q_push_data)
  );

  // Decoupling queue
  tee_queue #(
    .DATA_W (ENT_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_pop_data)
  );

  // Table engine
  tee_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .TIME_BITS   (TIME_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_data       (q_pop_data),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_kind     (out_kind),
    .out_fired_id (out_fired_id),
    .out_last     (out_last),
    .fill_o       (fill_cnt)
  );

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_cnt <= CNT_W'(TABLE_DEPTH))
    else $error("fill count exceeds table depth");

  a_add_reply: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != KIND_FIRED) |-> out_last && (out_fired_id == '0))
    else $error("add reply without last or with nonzero id");

  a_fired_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_FIRED) |-> (out_fired_id != '0))
    else $error("fired word carries id zero");

endmodule

// ===== tb/tee_expiry_checker.sv =====
// ----------------------------------------------------------------------------
// tee_expiry_checker
// Watches both channels of the timed event expiry table, keeps its own copy
// of the event table, works out the words each accepted command must return
// and compares every returned word with the oldest one still owed.
// ----------------------------------------------------------------------------
module tee_expiry_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              in_cmd,
  input  tee_pkg::in_time_t in_now_time,
  input  tee_pkg::in_time_t in_delay,
  input  tee_pkg::id_t      in_target_id,
  input  logic              out_valid,
  input  logic              out_stall,
  input  tee_pkg::kind_t    out_kind,
  input  tee_pkg::id_t      out_fired_id,
  input  logic              out_last,
  output int                fail_count,
  output int                expected_left
);
  import tee_pkg::*;

  localparam int SLOTS = 16;

  typedef struct packed {
    kind_t kind;
    id_t   fired_id;
    logic  last;
  } result_word_t;

  // Shadow table, packed oldest first
  in_time_t     shadow_trigger [SLOTS];
  id_t          shadow_target  [SLOTS];
  int           shadow_fill;
  result_word_t owed_words [$];

  // Update the shadow table for one command and queue the words it returns
  task automatic apply_command(input logic cmd, input in_time_t now, input in_time_t dly,
                               input id_t tid);
    result_word_t w;
    result_word_t fired [$];
    int keep;
    if (cmd == CMD_ADD) begin
      w.fired_id = '0;
      w.last     = 1'b1;
      if (shadow_fill >= SLOTS) begin
        w.kind = KIND_FULL;
      end else begin
        w.kind = KIND_ACCEPT;
        shadow_trigger[shadow_fill] = now + dly;  // wraps at 32 bits
        shadow_target[shadow_fill]  = tid;
        shadow_fill++;
      end
      owed_words.push_back(w);
    end else begin
      keep = 0;
      for (int i = 0; i < shadow_fill; i++) begin
        if (shadow_trigger[i] <= now) begin
          // expired; zero ids leave without a word
          if (shadow_target[i] != '0) begin
            w.kind     = KIND_FIRED;
            w.fired_id = shadow_target[i];
            w.last     = 1'b0;
            fired.push_back(w);
          end
        end else begin
          shadow_trigger[keep] = shadow_trigger[i];
          shadow_target[keep]  = shadow_target[i];
          keep++;
        end
      end
      shadow_fill = keep;
      for (int i = 0; i < fired.size(); i++) begin
        w = fired[i];
        if (i == fired.size() - 1) w.last = 1'b1;
        owed_words.push_back(w);
      end
    end
  endtask

  // Output side first: a word can never come from the command taken this edge
  always @(posedge clk) begin
    result_word_t want;
    if (!rst_n) begin
      owed_words.delete();
      shadow_fill   = 0;
      fail_count    = 0;
      expected_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_words.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual kind %0d id %h last %0b",
                   $time, out_kind, out_fired_id, out_last);
          fail_count++;
        end else begin
          want = owed_words.pop_front();
          if (out_kind !== want.kind) begin
            $display("%0t: out_kind mismatch, expected %0d, actual %0d",
                     $time, want.kind, out_kind);
            fail_count++;
          end
          if (out_fired_id !== want.fired_id) begin
            $display("%0t: out_fired_id mismatch, expected %h, actual %h",
                     $time, want.fired_id, out_fired_id);
            fail_count++;
          end
          if (out_last !== want.last) begin
            $display("%0t: out_last mismatch, expected %0b, actual %0b",
                     $time, want.last, out_last);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        apply_command(in_cmd, in_now_time, in_delay, in_target_id);
      end
      expected_left = owed_words.size();
    end
  end

endmodule

// ===== tb/tb_timed_event_expiry_table.sv =====
// ----------------------------------------------------------------------------
// tb_timed_event_expiry_table
// Drives add and tick words into the timed event expiry table: a directed
// pass over the corner cases (wrapped trigger times, zero ids, full table,
// empty ticks), then random add bursts and ticks under four idle/stall mixes.
// The checker beside the block predicts and compares; this module decides.
// ----------------------------------------------------------------------------
module tb_timed_event_expiry_table;
  import tee_pkg::*;

  localparam int SLOTS            = 16;
  localparam int RANDOM_PER_PHASE = 84;
  localparam int SETTLE_CYCLES    = SLOTS + 8;

  logic     clk;
  logic     rst_n        = 1'b0;
  logic     in_valid     = 1'b0;
  logic     in_stall;
  logic     in_cmd       = CMD_ADD;
  in_time_t in_now_time  = '0;
  in_time_t in_delay     = '0;
  id_t      in_target_id = '0;
  logic     out_valid;
  logic     out_stall    = 1'b0;
  kind_t    out_kind;
  id_t      out_fired_id;
  logic     out_last;

  int       fail_count;
  int       expected_left;
  int       send_idle_pct  = 0;
  int       recv_stall_pct = 0;
  in_time_t uptime         = '0;

  timed_event_expiry_table u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_now_time  (in_now_time),
    .in_delay     (in_delay),
    .in_target_id (in_target_id),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_kind     (out_kind),
    .out_fired_id (out_fired_id),
    .out_last     (out_last)
  );

  tee_expiry_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_now_time   (in_now_time),
    .in_delay      (in_delay),
    .in_target_id  (in_target_id),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_kind      (out_kind),
    .out_fired_id  (out_fired_id),
    .out_last      (out_last),
    .fail_count    (fail_count),
    .expected_left (expected_left)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #5000000;
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(0, 99) < recv_stall_pct);
  end

  // One command word; called and returns at a falling edge
  task automatic send_word(input logic cmd, input in_time_t now, input in_time_t dly,
                           input id_t tid);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd       <= cmd;
    in_now_time  <= now;
    in_delay     <= dly;
    in_target_id <= tid;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Hold the sender until every owed word is back and the block has settled
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_left != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic in_time_t pick_delay();
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return 32'hFFFF_FFFF - $urandom_range(0, 50);  // wraps past zero
      default: return $urandom_range(0, 150);
    endcase
  endfunction

  function automatic id_t pick_id();
    if ($urandom_range(0, 7) == 0) return '0;
    return id_t'($urandom_range(1, 65535));
  endfunction

  // Mostly add bursts followed by a tick on a rising uptime; some noise
  task automatic run_random(input int n_items);
    int done;
    int burst;
    int choice;
    done = 0;
    while (done < n_items) begin
      choice = $urandom_range(0, 9);
      if (choice < 7) begin
        burst = ($urandom_range(0, 4) == 0) ? $urandom_range(14, 19) : $urandom_range(1, 6);
        for (int k = 0; k < burst; k++) begin
          send_word(CMD_ADD, uptime, pick_delay(), pick_id());
          uptime += $urandom_range(0, 16);
          done++;
        end
        uptime += $urandom_range(0, 120);
        send_word(CMD_TICK, uptime, $urandom, id_t'($urandom));
        done++;
      end else if (choice < 9) begin
        send_word(1'($urandom_range(0, 1)), $urandom, $urandom, id_t'($urandom));
        done++;
      end else begin
        // pause for all results, then jump the uptime, sometimes near wrap
        drain();
        uptime = $urandom_range(0, 1) ? in_time_t'($urandom) : 32'hFFFF_FF00;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, wrapped trigger times, zero id
    send_word(CMD_ADD, 32'h0, 32'h0, 16'hFFFF);
    send_word(CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0001);
    send_word(CMD_ADD, 32'hFFFF_FFF0, 32'h0000_0020, 16'h0002);
    send_word(CMD_ADD, 32'h5, 32'h0, 16'h0000);
    send_word(CMD_ADD, 32'd100, 32'd50, 16'h8000);
    send_word(CMD_TICK, 32'h0, 32'h0, 16'h0);
    // delay and id are don't-care on a tick
    send_word(CMD_TICK, 32'h10, 32'hFFFF_FFFF, 16'hFFFF);
    send_word(CMD_TICK, 32'h3, 32'h0, 16'h0);
    // fill the table, one more add is rejected, then fire everything
    for (int k = 0; k < SLOTS - 2; k++) begin
      send_word(CMD_ADD, 32'h1000 + k, k, (k == 5) ? 16'h0 : id_t'(16'h1111 * (k + 1)));
    end
    send_word(CMD_ADD, 32'hFFFF_FFFF, 32'h0, 16'hAAAA);
    send_word(CMD_TICK, 32'hFFFF_FFFF, 32'h0, 16'h0);
    send_word(CMD_TICK, 32'h0, 32'h0, 16'h0);
    drain();

    // Random phases: no idling, sender idle, receiver stall, both
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      uptime = $urandom_range(0, 1000);
      run_random(RANDOM_PER_PHASE);
      drain();
    end

    if (fail_count == 0 && expected_left == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
